@@ rtl/core/bmf_pkg.sv @@
// Shared types, sizes and command codes of the banked mapper.
package bmf_pkg;

  localparam int FLASH_BYTES    = 1048576;
  localparam int SECTOR_BYTES   = 131072;
  localparam int PAGE_BYTES     = 128;
  localparam int BANK_BYTES     = 8192;
  localparam int RAM_BANK_BYTES = 4096;
  localparam int HIDDEN_BYTES   = 256;

  localparam int FLASH_AW    = $clog2(FLASH_BYTES);
  localparam int SECTOR_AW   = $clog2(SECTOR_BYTES);
  localparam int PAGE_AW     = $clog2(PAGE_BYTES);
  localparam int BANK_AW     = $clog2(BANK_BYTES);
  localparam int RAM_BANK_AW = $clog2(RAM_BANK_BYTES);
  localparam int HIDDEN_AW   = $clog2(HIDDEN_BYTES);
  localparam int RAM_BANK_W  = 3;
  localparam int RAM_AW      = RAM_BANK_AW + RAM_BANK_W;
  localparam int ROM_BANK_W  = 7;
  localparam int WIN_AW      = ROM_BANK_W + BANK_AW;
  localparam int ROM_SIZE_W  = 21;
  localparam int OFF_W       = 20;
  localparam int CNT_W       = ROM_SIZE_W - BANK_AW + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [14:0] UNLOCK_ADDR_A = 15'h5555;
  localparam logic [14:0] UNLOCK_ADDR_B = 15'h2AAA;

  localparam logic [7:0] ID_MAKER      = 8'hC2;
  localparam logic [7:0] ID_DEVICE     = 8'h81;
  localparam logic [7:0] ID_NONE       = 8'h00;
  localparam logic [7:0] BYTE_ERASED   = 8'hFF;
  localparam logic [7:0] STATUS_BASE   = 8'h80;
  localparam logic [7:0] KEY_A         = 8'hAA;
  localparam logic [7:0] KEY_B         = 8'h55;
  localparam logic [7:0] CMD_RESET     = 8'hF0;
  localparam logic [7:0] CMD_ID        = 8'h90;
  localparam logic [7:0] CMD_PROGRAM   = 8'hA0;
  localparam logic [7:0] CMD_ERASE     = 8'h80;
  localparam logic [7:0] CMD_EXTENDED  = 8'h60;
  localparam logic [7:0] CMD_HIDDEN    = 8'h77;
  localparam logic [7:0] CMD_CHIP      = 8'h10;
  localparam logic [7:0] CMD_SECTOR    = 8'h30;
  localparam logic [7:0] CMD_HID_ERASE = 8'h04;
  localparam logic [7:0] CMD_PROTECT   = 8'h20;
  localparam logic [7:0] CMD_UNPROTECT = 8'h40;
  localparam logic [7:0] CMD_HID_PROG  = 8'hE0;
  localparam logic [3:0] RAM_KEY       = 4'hA;

  typedef enum logic [1:0] {
    ROUTE_LOCAL  = 2'd0,
    ROUTE_ROM    = 2'd1,
    ROUTE_SYSTEM = 2'd2
  } route_t;

  typedef enum logic [3:0] {
    CL_SYSTEM,
    CL_RAM_EN,
    CL_RAM_BANK_LO,
    CL_RAM_BANK_HI,
    CL_FLASH_EN,
    CL_FLASH_WE,
    CL_NOP,
    CL_ROM_BANK_LO,
    CL_SEL_LO,
    CL_ROM_BANK_HI,
    CL_SEL_HI,
    CL_WIN_RD,
    CL_WIN_WR,
    CL_RAM_RD,
    CL_RAM_WR
  } class_t;

  typedef struct packed {
    class_t      cls;
    logic [15:0] addr;
    logic [7:0]  data;
  } q_item_t;

endpackage

@@ rtl/core/bmf_front.sv @@
// Front end: classify each bus access by direction and address region.
module bmf_front
  import bmf_pkg::*;
(
  input  logic        mode,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output q_item_t     item
);

  class_t cls;

  always_comb begin
    cls = CL_SYSTEM;
    if (!mode) begin
      if (bus_address[15:14] == 2'b01) begin
        cls = CL_WIN_RD;
      end else if (bus_address[15:13] == 3'b101) begin
        cls = CL_RAM_RD;
      end
    end else begin
      if (bus_address[15:14] == 2'b00) begin
        case (bus_address[13:10])
          4'h0: cls = CL_RAM_EN;
          4'h1: cls = CL_RAM_BANK_LO;
          4'h2: cls = CL_RAM_BANK_HI;
          4'h3: cls = CL_FLASH_EN;
          4'h4, 4'h5, 4'h6, 4'h7: begin
            cls = (bus_address == 16'h1000) ? CL_FLASH_WE : CL_NOP;
          end
          4'h8, 4'h9: cls = CL_ROM_BANK_LO;
          4'hA, 4'hB: cls = CL_SEL_LO;
          4'hC, 4'hD: cls = CL_ROM_BANK_HI;
          default:    cls = CL_SEL_HI;
        endcase
      end else if (bus_address[15:14] == 2'b01) begin
        cls = CL_WIN_WR;
      end else if (bus_address[15:13] == 3'b101) begin
        cls = CL_RAM_WR;
      end
    end
  end

  assign item.cls  = cls;
  assign item.addr = bus_address;
  assign item.data = write_data;

endmodule

@@ rtl/core/bmf_fifo.sv @@
// Short queue of classified items between front and back.
module bmf_fifo
  import bmf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  q_item_t wr_item,
  input  logic    rd,
  output q_item_t rd_item,
  output logic    q_full,
  output logic    q_empty
);

  localparam int CW = $clog2(Q_DEPTH + 1);

  q_item_t         slots [Q_DEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  logic [CW-1:0]   count;

  assign q_full  = (count == CW'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/bmf_back.sv @@
// Back end: mapper registers, flash command machine, stores and result register.
module bmf_back
  import bmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [ROM_SIZE_W-1:0] cfg_wdata,
  input  logic                  q_empty,
  input  q_item_t               head,
  output logic                  q_pop,
  output logic                  clearing,
  output logic                  res_valid,
  input  logic                  res_pop,
  output logic [1:0]            res_route,
  output logic [7:0]            res_data,
  output logic [OFF_W-1:0]      res_roff,
  output logic                  res_notify
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_MOD, S_ROM, S_SW_RD, S_SW_WR
  } state_t;

  typedef enum logic [2:0] {
    RM_ARRAY, RM_ID, RM_HIDDEN, RM_PROG_MAIN, RM_PROG_HIDDEN, RM_STATUS
  } rmode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UNLOCK1, ST_COMMAND, ST_SECOND_UNLOCK1, ST_SECOND_UNLOCK2,
    ST_SECOND_COMMAND
  } step_t;

  typedef enum logic [1:0] {
    PF_NONE, PF_ERASE, PF_EXTENDED, PF_HIDDEN_READ
  } prefix_t;

  typedef enum logic [1:0] {
    SRC_FLASH, SRC_HIDDEN, SRC_RAM
  } src_t;

  localparam logic [FLASH_AW-1:0] SECTOR_MASK = FLASH_AW'(SECTOR_BYTES - 1);
  localparam logic [FLASH_AW-1:0] PAGE_MASK   = FLASH_AW'(PAGE_BYTES - 1);
  localparam logic [FLASH_AW-1:0] CHIP_LOCKED = FLASH_AW'(SECTOR_BYTES);
  localparam bit LOCKED_CHIP_EMPTY            = SECTOR_BYTES >= FLASH_BYTES;

  state_t                 state;
  rmode_t                 read_mode;
  step_t                  command_step;
  prefix_t                command_prefix;
  src_t                   rd_src;
  logic [ROM_SIZE_W-1:0]  rom_size;
  logic [RAM_BANK_W-1:0]  ram_bank_lo;
  logic [RAM_BANK_W-1:0]  ram_bank_hi;
  logic [ROM_BANK_W-1:0]  rom_bank_lo;
  logic [ROM_BANK_W-1:0]  rom_bank_hi;
  logic                   ram_enabled;
  logic                   flash_enabled;
  logic                   flash_write_enabled;
  logic                   lo_is_flash;
  logic                   hi_is_flash;
  logic                   sector_zero_protected;
  logic [PAGE_AW-1:0]     last_pos;
  logic                   last_pos_valid;
  logic [PAGE_BYTES-1:0]  pb_valid;
  logic [FLASH_AW-1:0]    clr;
  logic [FLASH_AW-1:0]    sw_addr;
  logic [FLASH_AW-1:0]    sw_last;
  logic                   sw_flash;
  logic                   sw_and;
  logic                   sw_notify;
  logic [ROM_BANK_W-1:0]  mod_bank;
  logic [2:0]             mod_i;
  logic [CNT_W-1:0]       rem;
  logic [BANK_AW-1:0]     cur_low;

  logic [7:0] flash_mem  [FLASH_BYTES];
  logic [7:0] hidden_mem [HIDDEN_BYTES];
  logic [7:0] ram_mem    [1 << RAM_AW];
  logic [7:0] pb_mem     [PAGE_BYTES];
  logic [7:0] flash_rdata;
  logic [7:0] hidden_rdata;
  logic [7:0] ram_rdata;
  logic [7:0] pb_rdata;

  // Decode of the item at the queue head.
  logic                  take;
  logic                  win_fl;
  logic [ROM_BANK_W-1:0] win_bank;
  logic [WIN_AW-1:0]     wa;
  logic [FLASH_AW-1:0]   fa;
  logic                  is_a;
  logic                  is_b;
  logic                  locked;
  logic                  wa_sector0;
  logic [7:0]            v;
  logic [PAGE_AW-1:0]    pos;
  logic                  prog_mode;
  logic                  flash_wr;
  logic                  pb_we;
  logic [RAM_AW-1:0]     ram_addr;
  logic [7:0]            id_byte;
  logic [7:0]            status_byte;
  logic [CNT_W-1:0]      rom_banks;
  logic [CNT_W:0]        mod_trial;
  logic [OFF_W-1:0]      rom_off;
  logic [FLASH_AW-1:0]   hid_base;

  // Sweep datapath.
  logic [7:0] sw_old;
  logic [7:0] sw_buf;
  logic [7:0] sw_new;
  logic       sw_change;

  assign take        = (state == S_IDLE) && !q_empty && !res_valid;
  assign q_pop       = take;
  assign clearing    = (state == S_CLEAR);
  assign win_fl      = head.addr[13] ? hi_is_flash : lo_is_flash;
  assign win_bank    = head.addr[13] ? rom_bank_hi : rom_bank_lo;
  assign wa          = {win_bank, head.addr[BANK_AW-1:0]};
  assign fa          = wa[FLASH_AW-1:0];
  assign is_a        = (wa[14:0] == UNLOCK_ADDR_A);
  assign is_b        = (wa[14:0] == UNLOCK_ADDR_B);
  assign locked      = !flash_write_enabled || sector_zero_protected;
  assign wa_sector0  = (WIN_AW'(wa >> SECTOR_AW) == '0);
  assign v           = head.data;
  assign pos         = fa[PAGE_AW-1:0];
  assign prog_mode   = (read_mode == RM_PROG_MAIN) || (read_mode == RM_PROG_HIDDEN);
  assign flash_wr    = take && (head.cls == CL_WIN_WR) && win_fl && flash_enabled;
  assign pb_we       = flash_wr && (v != CMD_RESET) && prog_mode
                       && !(last_pos_valid && (pos == last_pos));
  assign ram_addr    = {head.addr[12] ? ram_bank_hi : ram_bank_lo,
                        head.addr[RAM_BANK_AW-1:0]};
  assign status_byte = STATUS_BASE | {6'd0, sector_zero_protected, 1'b0};
  assign hid_base    = FLASH_AW'(fa[HIDDEN_AW-1:0] & ~HIDDEN_AW'(PAGE_BYTES - 1));

  always_comb begin
    case (fa[1:0])
      2'd0:    id_byte = ID_MAKER;
      2'd1:    id_byte = ID_DEVICE;
      2'd2:    id_byte = (FLASH_AW'(fa >> SECTOR_AW) == '0) ? ID_MAKER : ID_NONE;
      default: id_byte = BYTE_ERASED;
    endcase
  end

  // Bank count of the ROM, at least one.
  always_comb begin
    rom_banks = CNT_W'(rom_size[ROM_SIZE_W-1:BANK_AW]) + CNT_W'(|rom_size[BANK_AW-1:0]);
    if (rom_banks == '0) begin
      rom_banks = CNT_W'(1);
    end
  end

  assign mod_trial = {rem, mod_bank[ROM_BANK_W-1]};
  assign rom_off   = {rem[ROM_BANK_W-1:0], cur_low};

  assign sw_old    = sw_flash ? flash_rdata : hidden_rdata;
  assign sw_buf    = pb_valid[sw_addr[PAGE_AW-1:0]] ? pb_rdata : BYTE_ERASED;
  assign sw_new    = sw_and ? (sw_old & sw_buf) : BYTE_ERASED;
  assign sw_change = (sw_new != sw_old);

  // Flash array.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      flash_mem[clr] <= BYTE_ERASED;
    end else if ((state == S_SW_WR) && sw_flash && sw_change) begin
      flash_mem[sw_addr] <= sw_new;
    end
    flash_rdata <= flash_mem[(state == S_SW_RD) ? sw_addr : fa];
  end

  // Hidden sector.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      hidden_mem[clr[HIDDEN_AW-1:0]] <= BYTE_ERASED;
    end else if ((state == S_SW_WR) && !sw_flash && sw_change) begin
      hidden_mem[sw_addr[HIDDEN_AW-1:0]] <= sw_new;
    end
    hidden_rdata <= hidden_mem[(state == S_SW_RD) ? sw_addr[HIDDEN_AW-1:0]
                                                  : fa[HIDDEN_AW-1:0]];
  end

  // Banked RAM.
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      ram_mem[clr[RAM_AW-1:0]] <= BYTE_ERASED;
    end else if (take && (head.cls == CL_RAM_WR) && ram_enabled) begin
      ram_mem[ram_addr] <= head.data;
    end
    ram_rdata <= ram_mem[ram_addr];
  end

  // Page buffer; entries without a valid bit read as erased.
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[pos] <= v;
    end
    pb_rdata <= pb_mem[sw_addr[PAGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= S_CLEAR;
      clr                   <= '0;
      rom_size              <= ROM_SIZE_W'(FLASH_BYTES);
      ram_bank_lo           <= RAM_BANK_W'(0);
      ram_bank_hi           <= RAM_BANK_W'(1);
      rom_bank_lo           <= ROM_BANK_W'(2);
      rom_bank_hi           <= ROM_BANK_W'(3);
      ram_enabled           <= 1'b0;
      flash_enabled         <= 1'b0;
      flash_write_enabled   <= 1'b0;
      lo_is_flash           <= 1'b0;
      hi_is_flash           <= 1'b0;
      sector_zero_protected <= 1'b0;
      read_mode             <= RM_ARRAY;
      command_step          <= ST_IDLE;
      command_prefix        <= PF_NONE;
      last_pos              <= '0;
      last_pos_valid        <= 1'b0;
      pb_valid              <= '0;
      res_valid             <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        rom_size <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (take) begin
            res_valid  <= 1'b1;
            res_route  <= ROUTE_LOCAL;
            res_data   <= '0;
            res_roff   <= '0;
            res_notify <= 1'b0;
            case (head.cls)
              CL_SYSTEM: res_route <= ROUTE_SYSTEM;
              CL_RAM_EN: begin
                ram_enabled <= (v[3:0] == RAM_KEY);
                res_notify  <= ram_enabled && (v[3:0] != RAM_KEY);
              end
              CL_RAM_BANK_LO: ram_bank_lo <= v[RAM_BANK_W-1:0];
              CL_RAM_BANK_HI: ram_bank_hi <= v[RAM_BANK_W-1:0];
              CL_FLASH_EN:    flash_enabled <= v[0];
              CL_FLASH_WE:    flash_write_enabled <= v[0];
              CL_ROM_BANK_LO: rom_bank_lo <= v[ROM_BANK_W-1:0];
              CL_ROM_BANK_HI: rom_bank_hi <= v[ROM_BANK_W-1:0];
              CL_SEL_LO:      lo_is_flash <= v[3];
              CL_SEL_HI:      hi_is_flash <= v[3];
              CL_RAM_RD: begin
                if (ram_enabled) begin
                  rd_src    <= SRC_RAM;
                  state     <= S_RD;
                  res_valid <= 1'b0;
                end else begin
                  res_data <= BYTE_ERASED;
                end
              end
              CL_WIN_RD: begin
                if (!win_fl) begin
                  // Reduce the bank modulo the bank count, one bit a cycle.
                  mod_bank  <= win_bank;
                  mod_i     <= 3'(ROM_BANK_W - 1);
                  rem       <= '0;
                  cur_low   <= head.addr[BANK_AW-1:0];
                  state     <= S_MOD;
                  res_valid <= 1'b0;
                end else if (!flash_enabled) begin
                  res_data <= BYTE_ERASED;
                end else begin
                  case (read_mode)
                    RM_ARRAY: begin
                      rd_src    <= SRC_FLASH;
                      state     <= S_RD;
                      res_valid <= 1'b0;
                    end
                    RM_HIDDEN: begin
                      rd_src    <= SRC_HIDDEN;
                      state     <= S_RD;
                      res_valid <= 1'b0;
                    end
                    RM_ID:   res_data <= id_byte;
                    default: res_data <= status_byte;
                  endcase
                end
              end
              CL_WIN_WR: begin
                if (flash_wr) begin
                  if (v == CMD_RESET) begin
                    command_step   <= ST_IDLE;
                    command_prefix <= PF_NONE;
                    read_mode      <= RM_ARRAY;
                    pb_valid       <= '0;
                    last_pos       <= '0;
                    last_pos_valid <= 1'b0;
                  end else if (prog_mode) begin
                    if (last_pos_valid && (pos == last_pos)) begin
                      // A write that repeats the last position commits the page.
                      read_mode      <= RM_STATUS;
                      last_pos       <= '0;
                      last_pos_valid <= 1'b0;
                      if (read_mode == RM_PROG_MAIN) begin
                        if (!(wa_sector0 && locked)
                            && (WIN_AW'(wa >> FLASH_AW) == '0)) begin
                          sw_addr   <= fa & ~PAGE_MASK;
                          sw_last   <= fa | PAGE_MASK;
                          sw_flash  <= 1'b1;
                          sw_and    <= 1'b1;
                          sw_notify <= 1'b0;
                          state     <= S_SW_RD;
                          res_valid <= 1'b0;
                        end
                      end else if (flash_write_enabled) begin
                        sw_addr   <= hid_base;
                        sw_last   <= hid_base | PAGE_MASK;
                        sw_flash  <= 1'b0;
                        sw_and    <= 1'b1;
                        sw_notify <= 1'b0;
                        state     <= S_SW_RD;
                        res_valid <= 1'b0;
                      end
                    end else begin
                      pb_valid[pos]  <= 1'b1;
                      last_pos       <= pos;
                      last_pos_valid <= 1'b1;
                    end
                  end else if ((read_mode != RM_ID) && (read_mode != RM_HIDDEN)) begin
                    case (command_step)
                      ST_IDLE: begin
                        if (is_a && (v == KEY_A)) begin
                          command_step <= ST_UNLOCK1;
                        end
                      end
                      ST_UNLOCK1: begin
                        if (is_b && (v == KEY_B)) begin
                          command_step <= ST_COMMAND;
                        end else begin
                          command_step   <= ST_IDLE;
                          command_prefix <= PF_NONE;
                        end
                      end
                      ST_COMMAND: begin
                        command_step   <= ST_IDLE;
                        command_prefix <= PF_NONE;
                        if (is_a) begin
                          if (v == CMD_ID) begin
                            read_mode <= RM_ID;
                          end else if (v == CMD_PROGRAM) begin
                            read_mode      <= RM_PROG_MAIN;
                            pb_valid       <= '0;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                          end else if (v == CMD_ERASE) begin
                            command_prefix <= PF_ERASE;
                            command_step   <= ST_SECOND_UNLOCK1;
                          end else if (v == CMD_EXTENDED) begin
                            command_prefix <= PF_EXTENDED;
                            command_step   <= ST_SECOND_UNLOCK1;
                          end else if (v == CMD_HIDDEN) begin
                            command_prefix <= PF_HIDDEN_READ;
                            command_step   <= ST_SECOND_UNLOCK1;
                          end
                        end
                      end
                      ST_SECOND_UNLOCK1: begin
                        if (is_a && (v == KEY_A)) begin
                          command_step <= ST_SECOND_UNLOCK2;
                        end else begin
                          command_step   <= ST_IDLE;
                          command_prefix <= PF_NONE;
                        end
                      end
                      ST_SECOND_UNLOCK2: begin
                        if (is_b && (v == KEY_B)) begin
                          command_step <= ST_SECOND_COMMAND;
                        end else begin
                          command_step   <= ST_IDLE;
                          command_prefix <= PF_NONE;
                        end
                      end
                      ST_SECOND_COMMAND: begin
                        command_step   <= ST_IDLE;
                        command_prefix <= PF_NONE;
                        if (command_prefix == PF_ERASE) begin
                          if ((v == CMD_CHIP) && is_a) begin
                            read_mode      <= RM_STATUS;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                            if (!(locked && LOCKED_CHIP_EMPTY)) begin
                              sw_addr   <= locked ? CHIP_LOCKED : '0;
                              sw_last   <= '1;
                              sw_flash  <= 1'b1;
                              sw_and    <= 1'b0;
                              sw_notify <= 1'b0;
                              state     <= S_SW_RD;
                              res_valid <= 1'b0;
                            end
                          end else if (v == CMD_SECTOR) begin
                            read_mode      <= RM_STATUS;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                            if (!((FLASH_AW'(fa >> SECTOR_AW) == '0) && locked)) begin
                              sw_addr   <= fa & ~SECTOR_MASK;
                              sw_last   <= fa | SECTOR_MASK;
                              sw_flash  <= 1'b1;
                              sw_and    <= 1'b0;
                              sw_notify <= 1'b0;
                              state     <= S_SW_RD;
                              res_valid <= 1'b0;
                            end
                          end
                        end else if ((command_prefix == PF_EXTENDED)
                                     && flash_write_enabled) begin
                          if ((v == CMD_HID_ERASE) && is_a) begin
                            read_mode      <= RM_STATUS;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                            sw_addr        <= '0;
                            sw_last        <= FLASH_AW'(HIDDEN_BYTES - 1);
                            sw_flash       <= 1'b0;
                            sw_and         <= 1'b0;
                            sw_notify      <= 1'b0;
                            state          <= S_SW_RD;
                            res_valid      <= 1'b0;
                          end else if (((v == CMD_PROTECT) || (v == CMD_UNPROTECT))
                                       && wa_sector0) begin
                            sector_zero_protected <= (v == CMD_PROTECT);
                            res_notify <= sector_zero_protected != (v == CMD_PROTECT);
                            read_mode      <= RM_STATUS;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                          end else if ((v == CMD_HID_PROG) && is_a) begin
                            read_mode      <= RM_PROG_HIDDEN;
                            pb_valid       <= '0;
                            last_pos       <= '0;
                            last_pos_valid <= 1'b0;
                          end
                        end else if (command_prefix == PF_HIDDEN_READ) begin
                          if ((v == CMD_HIDDEN) && is_a) begin
                            read_mode <= RM_HIDDEN;
                          end
                        end
                      end
                      default: begin
                        command_step   <= ST_IDLE;
                        command_prefix <= PF_NONE;
                      end
                    endcase
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_RD: begin
          res_valid  <= 1'b1;
          res_route  <= ROUTE_LOCAL;
          res_roff   <= '0;
          res_notify <= 1'b0;
          case (rd_src)
            SRC_FLASH:  res_data <= flash_rdata;
            SRC_HIDDEN: res_data <= hidden_rdata;
            default:    res_data <= ram_rdata;
          endcase
          state <= S_IDLE;
        end

        S_MOD: begin
          if (mod_trial >= {1'b0, rom_banks}) begin
            rem <= CNT_W'(mod_trial - {1'b0, rom_banks});
          end else begin
            rem <= mod_trial[CNT_W-1:0];
          end
          mod_bank <= {mod_bank[ROM_BANK_W-2:0], 1'b0};
          mod_i    <= mod_i - 1'b1;
          if (mod_i == '0) begin
            state <= S_ROM;
          end
        end

        S_ROM: begin
          res_valid  <= 1'b1;
          res_notify <= 1'b0;
          if (ROM_SIZE_W'(rom_off) < rom_size) begin
            res_route <= ROUTE_ROM;
            res_roff  <= rom_off;
            res_data  <= '0;
          end else begin
            res_route <= ROUTE_LOCAL;
            res_roff  <= '0;
            res_data  <= BYTE_ERASED;
          end
          state <= S_IDLE;
        end

        S_SW_RD: state <= S_SW_WR;

        S_SW_WR: begin
          if (sw_addr == sw_last) begin
            res_valid  <= 1'b1;
            res_route  <= ROUTE_LOCAL;
            res_data   <= '0;
            res_roff   <= '0;
            res_notify <= sw_notify || sw_change;
            state      <= S_IDLE;
          end else begin
            sw_notify <= sw_notify || sw_change;
            sw_addr   <= sw_addr + 1'b1;
            state     <= S_SW_RD;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/banked_mapper_with_flash_commands.sv @@
// Banked cartridge mapper with flash command machine: front decode, queue, back end.
// Register and status accesses are answered in the idle state; flash, hidden and RAM
// array reads pass through the read state; ROM window reads run the bit-serial bank modulo.
// Page commits (128 bytes) and erases sweep each byte through a read and a write state.
// One item is executed at a time; a two-entry queue takes new items while a result waits.
// After reset a clearing pass fills flash, hidden and RAM with 0xFF while full stays high.
module banked_mapper_with_flash_commands
  import bmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  mode,
  input  logic [15:0]           bus_address,
  input  logic [7:0]            write_data,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            route,
  output logic [7:0]            read_data,
  output logic [OFF_W-1:0]      rom_offset,
  output logic                  save_notify,
  input  logic                  rom_size_we,
  input  logic [ROM_SIZE_W-1:0] rom_size_wdata
);

  q_item_t in_item;
  q_item_t head;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    clearing;
  logic    res_valid;

  assign full  = q_full || clearing;
  assign empty = !res_valid;

  bmf_front u_front (
    .mode        (mode),
    .bus_address (bus_address),
    .write_data  (write_data),
    .item        (in_item)
  );

  bmf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (push && !full),
    .wr_item (in_item),
    .rd      (q_pop),
    .rd_item (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  bmf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (rom_size_we),
    .cfg_wdata  (rom_size_wdata),
    .q_empty    (q_empty),
    .head       (head),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_route  (route),
    .res_data   (read_data),
    .res_roff   (rom_offset),
    .res_notify (save_notify)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_empty)
    else $error("accepted item did not reach the queue");

  a_route_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (route == ROUTE_LOCAL || route == ROUTE_ROM || route == ROUTE_SYSTEM))
    else $error("route code out of range");

  a_offset_only_rom: assert property (@(posedge clk) disable iff (rst)
    (!empty && route != ROUTE_ROM) |-> rom_offset == '0)
    else $error("ROM offset set on a non-ROM result");

  a_rom_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && route == ROUTE_ROM) |-> read_data == 8'h00)
    else $error("read data set on a ROM result");

endmodule

@@ dv/bmf_checker.sv @@
// Checker for the banked mapper: predicts each result from the accepted accesses and compares.
module bmf_checker
  import bmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic                  mode,
  input  logic [15:0]           bus_address,
  input  logic [7:0]            write_data,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [1:0]            route,
  input  logic [7:0]            read_data,
  input  logic [OFF_W-1:0]      rom_offset,
  input  logic                  save_notify,
  input  logic                  rom_size_we,
  input  logic [ROM_SIZE_W-1:0] rom_size_wdata,
  output int                    errors,
  output int                    outstanding,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    CS_IDLE, CS_UNLOCK, CS_COMMAND, CS_SECOND_KEY_A, CS_SECOND_KEY_B, CS_SECOND_COMMAND
  } cmd_step_e;
  typedef enum int {PX_NONE, PX_ERASE, PX_EXTENDED, PX_HIDDEN_READ} cmd_prefix_e;
  typedef enum int {
    RD_ARRAY, RD_ID, RD_HIDDEN, RD_PROG_MAIN, RD_PROG_HIDDEN, RD_STATUS
  } read_mode_e;

  typedef struct {
    route_t           rt;
    logic [7:0]       data;
    logic [OFF_W-1:0] offset;
    logic             notify;
  } access_result_t;

  logic [ROM_SIZE_W-1:0] rom_size;
  logic [2:0]  ram_bank_lo, ram_bank_hi;
  logic [6:0]  rom_bank_lo, rom_bank_hi;
  bit          ram_on, flash_on, flash_wr_on, lo_is_flash, hi_is_flash;
  cmd_step_e   step;
  cmd_prefix_e prefix;
  read_mode_e  rd_mode;
  logic [7:0]  page_buf [PAGE_BYTES];
  int unsigned last_pos;
  bit          pos_valid;
  bit          sector0_prot;
  bit          notify;
  logic [7:0]  ram_mem    [8*RAM_BANK_BYTES];
  logic [7:0]  flash_mem  [FLASH_BYTES];
  logic [7:0]  hidden_mem [HIDDEN_BYTES];
  access_result_t pending_results[$];
  bit          in_reset;

  function automatic void clear_page_buf();
    foreach (page_buf[i]) page_buf[i] = BYTE_ERASED;
    last_pos  = 0;
    pos_valid = 0;
  endfunction

  function automatic void to_status();
    rd_mode   = RD_STATUS;
    last_pos  = 0;
    pos_valid = 0;
  endfunction

  function automatic void go_idle();
    step   = CS_IDLE;
    prefix = PX_NONE;
  endfunction

  function automatic void reset_state();
    rom_size    = 21'd1048576;
    ram_bank_lo = 0;
    ram_bank_hi = 1;
    rom_bank_lo = 2;
    rom_bank_hi = 3;
    {ram_on, flash_on, flash_wr_on, lo_is_flash, hi_is_flash} = '0;
    go_idle();
    rd_mode      = RD_ARRAY;
    sector0_prot = 0;
    clear_page_buf();
    foreach (ram_mem[i]) ram_mem[i] = BYTE_ERASED;
    foreach (flash_mem[i]) flash_mem[i] = BYTE_ERASED;
    foreach (hidden_mem[i]) hidden_mem[i] = BYTE_ERASED;
  endfunction

  function automatic bit at_a(int unsigned fa);
    return fa[14:0] == UNLOCK_ADDR_A;
  endfunction

  function automatic bit sector0_locked();
    return !flash_wr_on || sector0_prot;
  endfunction

  // Erase only counts as a change when something was programmed.
  function automatic void erase_flash(int unsigned start, int unsigned n);
    bit dirty;
    dirty = 0;
    for (int unsigned i = 0; i < n; i++)
      if (flash_mem[start+i] != BYTE_ERASED) dirty = 1;
    if (dirty) begin
      for (int unsigned i = 0; i < n; i++) flash_mem[start+i] = BYTE_ERASED;
      notify = 1;
    end
  endfunction

  function automatic int unsigned window_addr(logic [15:0] a);
    logic [6:0] bank;
    bank = (a < 16'h6000) ? rom_bank_lo : rom_bank_hi;
    return int'(bank) * BANK_BYTES + int'(a[12:0]);
  endfunction

  function automatic logic [7:0] flash_fetch(int unsigned fa);
    fa = fa & (FLASH_BYTES - 1);
    case (rd_mode)
      RD_ID: begin
        case (fa[1:0])
          2'd0: return ID_MAKER;
          2'd1: return ID_DEVICE;
          2'd2: return (fa < SECTOR_BYTES) ? ID_MAKER : ID_NONE;
          default: return BYTE_ERASED;
        endcase
      end
      RD_HIDDEN: return hidden_mem[fa & (HIDDEN_BYTES - 1)];
      RD_PROG_MAIN, RD_PROG_HIDDEN, RD_STATUS: return STATUS_BASE | {6'd0, sector0_prot, 1'b0};
      default: return flash_mem[fa];
    endcase
  endfunction

  function automatic void commit_page(int unsigned fa);
    int unsigned base, k;
    logic [7:0] v;
    if (rd_mode == RD_PROG_MAIN) begin
      base = fa & ~(PAGE_BYTES - 1);
      if (!(base < SECTOR_BYTES && sector0_locked()) && base + PAGE_BYTES <= FLASH_BYTES)
        for (int unsigned i = 0; i < PAGE_BYTES; i++) begin
          v = flash_mem[base+i] & page_buf[i];
          if (v != flash_mem[base+i]) begin
            flash_mem[base+i] = v;
            notify = 1;
          end
        end
    end else if (rd_mode == RD_PROG_HIDDEN && flash_wr_on) begin
      base = fa & (HIDDEN_BYTES - 1) & ~(PAGE_BYTES - 1);
      for (int unsigned i = 0; i < PAGE_BYTES; i++) begin
        k = (base + i) & (HIDDEN_BYTES - 1);
        v = hidden_mem[k] & page_buf[i];
        if (v != hidden_mem[k]) begin
          hidden_mem[k] = v;
          notify = 1;
        end
      end
    end
    to_status();
  endfunction

  function automatic void second_command(int unsigned fa, logic [7:0] v);
    int unsigned start, n;
    if (prefix == PX_ERASE) begin
      if (v == CMD_CHIP && at_a(fa)) begin
        start = sector0_locked() ? SECTOR_BYTES : 0;
        if (start < FLASH_BYTES) erase_flash(start, FLASH_BYTES - start);
        to_status();
      end else if (v == CMD_SECTOR) begin
        start = ((fa & (FLASH_BYTES - 1)) / SECTOR_BYTES) * SECTOR_BYTES;
        if (!(start == 0 && sector0_locked())) begin
          n = SECTOR_BYTES;
          if (n > FLASH_BYTES - start) n = FLASH_BYTES - start;
          erase_flash(start, n);
        end
        to_status();
      end
    end else if (prefix == PX_EXTENDED && flash_wr_on) begin
      if (v == CMD_HID_ERASE && at_a(fa)) begin
        if (hidden_mem.sum() with (int'(item != BYTE_ERASED)) != 0) begin
          foreach (hidden_mem[i]) hidden_mem[i] = BYTE_ERASED;
          notify = 1;
        end
        to_status();
      end else if ((v == CMD_PROTECT || v == CMD_UNPROTECT) && fa < SECTOR_BYTES) begin
        if (sector0_prot != (v == CMD_PROTECT)) notify = 1;
        sector0_prot = (v == CMD_PROTECT);
        to_status();
      end else if (v == CMD_HID_PROG && at_a(fa)) begin
        clear_page_buf();
        rd_mode = RD_PROG_HIDDEN;
      end
    end else if (prefix == PX_HIDDEN_READ) begin
      if (v == CMD_HIDDEN && at_a(fa)) rd_mode = RD_HIDDEN;
    end
  endfunction

  function automatic void command_write(int unsigned fa, logic [7:0] v);
    case (step)
      CS_IDLE: if (at_a(fa) && v == KEY_A) step = CS_UNLOCK;
      CS_UNLOCK: begin
        if (fa[14:0] == UNLOCK_ADDR_B && v == KEY_B) step = CS_COMMAND;
        else go_idle();
      end
      CS_COMMAND: begin
        if (!at_a(fa)) go_idle();
        else if (v == CMD_ID) begin
          rd_mode = RD_ID;
          go_idle();
        end else if (v == CMD_PROGRAM) begin
          clear_page_buf();
          rd_mode = RD_PROG_MAIN;
          go_idle();
        end else if (v == CMD_ERASE || v == CMD_EXTENDED || v == CMD_HIDDEN) begin
          prefix = (v == CMD_ERASE) ? PX_ERASE : (v == CMD_EXTENDED) ? PX_EXTENDED
                                                                     : PX_HIDDEN_READ;
          step = CS_SECOND_KEY_A;
        end else go_idle();
      end
      CS_SECOND_KEY_A: begin
        if (at_a(fa) && v == KEY_A) step = CS_SECOND_KEY_B;
        else go_idle();
      end
      CS_SECOND_KEY_B: begin
        if (fa[14:0] == UNLOCK_ADDR_B && v == KEY_B) step = CS_SECOND_COMMAND;
        else go_idle();
      end
      default: begin
        second_command(fa, v);
        go_idle();
      end
    endcase
  endfunction

  function automatic void flash_write(int unsigned fa, logic [7:0] v);
    int unsigned pos;
    if (v == CMD_RESET) begin
      go_idle();
      rd_mode = RD_ARRAY;
      clear_page_buf();
    end else if (rd_mode == RD_PROG_MAIN || rd_mode == RD_PROG_HIDDEN) begin
      pos = fa & (PAGE_BYTES - 1);
      if (pos_valid && pos == last_pos) commit_page(fa);
      else begin
        page_buf[pos] = v;
        last_pos      = pos;
        pos_valid     = 1;
      end
    end else if (rd_mode != RD_ID && rd_mode != RD_HIDDEN) begin
      command_write(fa, v);
    end
  endfunction

  function automatic access_result_t map_access(bit wr, logic [15:0] a, logic [7:0] v);
    access_result_t r;
    int unsigned bank, cnt, off;
    bit fl, prev;
    r = '{ROUTE_LOCAL, 8'd0, '0, 1'b0};
    notify = 0;
    if (!wr) begin
      if (a < 16'h4000) r.rt = ROUTE_SYSTEM;
      else if (a < 16'h8000) begin
        fl = (a < 16'h6000) ? lo_is_flash : hi_is_flash;
        if (fl) r.data = flash_on ? flash_fetch(window_addr(a)) : BYTE_ERASED;
        else begin
          bank = (a < 16'h6000) ? rom_bank_lo : rom_bank_hi;
          cnt  = (int'(rom_size) + BANK_BYTES - 1) / BANK_BYTES;
          if (cnt < 1) cnt = 1;
          off = (bank % cnt) * BANK_BYTES + int'(a[12:0]);
          if (off < rom_size) begin
            r.rt     = ROUTE_ROM;
            r.offset = off[OFF_W-1:0];
          end else r.data = BYTE_ERASED;
        end
      end else if (a >= 16'hA000 && a < 16'hC000) begin
        bank   = (a < 16'hB000) ? ram_bank_lo : ram_bank_hi;
        r.data = ram_on ? ram_mem[bank*RAM_BANK_BYTES + a[11:0]] : BYTE_ERASED;
      end else r.rt = ROUTE_SYSTEM;
    end else begin
      if (a < 16'h0400) begin
        prev   = ram_on;
        ram_on = (v[3:0] == RAM_KEY);
        if (prev && !ram_on) notify = 1;
      end else if (a < 16'h0800) ram_bank_lo = v[2:0];
      else if (a < 16'h0C00) ram_bank_hi = v[2:0];
      else if (a < 16'h1000) flash_on = v[0];
      else if (a == 16'h1000) flash_wr_on = v[0];
      else if (a < 16'h2000) ;
      else if (a < 16'h2800) rom_bank_lo = v[6:0];
      else if (a < 16'h3000) lo_is_flash = v[3];
      else if (a < 16'h3800) rom_bank_hi = v[6:0];
      else if (a < 16'h4000) hi_is_flash = v[3];
      else if (a < 16'h8000) begin
        fl = (a < 16'h6000) ? lo_is_flash : hi_is_flash;
        if (fl && flash_on) flash_write(window_addr(a), v);
      end else if (a >= 16'hA000 && a < 16'hC000) begin
        bank = (a < 16'hB000) ? ram_bank_lo : ram_bank_hi;
        if (ram_on) ram_mem[bank*RAM_BANK_BYTES + a[11:0]] = v;
      end else r.rt = ROUTE_SYSTEM;
    end
    r.notify = notify;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t exp_r;
    if (rst) begin
      if (!in_reset) begin
        reset_state();
        errors  = 0;
        checked = 0;
      end
      in_reset = 1;
      pending_results.delete();
    end else begin
      in_reset = 0;
      if (rom_size_we) rom_size = rom_size_wdata;
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no access waiting: route %0d data %h", route, read_data);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          checked++;
          if (route !== exp_r.rt) begin
            $error("route: expected %0d, got %0d", exp_r.rt, route);
            errors++;
          end
          if (read_data !== exp_r.data) begin
            $error("read_data: expected %h, got %h", exp_r.data, read_data);
            errors++;
          end
          if (rom_offset !== exp_r.offset) begin
            $error("rom_offset: expected %h, got %h", exp_r.offset, rom_offset);
            errors++;
          end
          if (save_notify !== exp_r.notify) begin
            $error("save_notify: expected %0d, got %0d", exp_r.notify, save_notify);
            errors++;
          end
        end
      end
      if (push && !full) pending_results.push_back(map_access(mode, bus_address, write_data));
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ dv/tb_banked_mapper_with_flash_commands.sv @@
// Testbench top for the banked mapper: drives bus accesses and ROM size, gives the verdict.
module tb_banked_mapper_with_flash_commands;
  timeunit 1ns;
  timeprecision 1ps;
  import bmf_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  push = 0;
  logic                  mode = 0;
  logic [15:0]           bus_address = '0;
  logic [7:0]            write_data = '0;
  logic                  pop = 0;
  logic                  rom_size_we = 0;
  logic [ROM_SIZE_W-1:0] rom_size_wdata = '0;
  logic                  full, empty, save_notify;
  logic [1:0]            route;
  logic [7:0]            read_data;
  logic [OFF_W-1:0]      rom_offset;
  int                    errors, outstanding, checked;
  int                    n_accesses = 0;
  int                    burst_left = 0;
  int                    n_sizes = 0;
  bit                    push_high = 0;

  banked_mapper_with_flash_commands DUT (
    .clk, .rst, .push, .full, .mode, .bus_address, .write_data, .empty, .pop,
    .route, .read_data, .rom_offset, .save_notify, .rom_size_we, .rom_size_wdata
  );

  bmf_checker u_checker (
    .clk, .rst, .push, .full, .mode, .bus_address, .write_data, .empty, .pop,
    .route, .read_data, .rom_offset, .save_notify, .rom_size_we, .rom_size_wdata,
    .errors, .outstanding, .checked
  );

  always #5 clk = ~clk;

  // Receiver: change stall style now and then, including stretches with no stall.
  int pop_style = 0, pop_left = 0;
  always @(negedge clk) begin
    if (pop_left == 0) begin
      pop_style = $urandom_range(0, 2);
      pop_left  = $urandom_range(10, 80);
    end
    pop_left--;
    case (pop_style)
      0: pop <= 1'b1;
      1: pop <= $urandom_range(0, 1);
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic hold_off();
    if (push_high) push <= 1'b0;
    push_high = 0;
  endtask

  task automatic access(bit m, logic [15:0] a, logic [7:0] d);
    if (burst_left == 0) begin
      hold_off();
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    push        <= 1'b1;
    push_high   = 1;
    mode        <= m;
    bus_address <= a;
    write_data  <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    burst_left--;
    n_accesses++;
  endtask

  task automatic drain();
    hold_off();
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_rom_size(logic [ROM_SIZE_W-1:0] v);
    drain();
    rom_size_we    <= 1'b1;
    rom_size_wdata <= v;
    @(negedge clk);
    rom_size_we <= 1'b0;
    n_sizes++;
  endtask

  // Map flash in both windows: low bank aliases the 0x5555 key address, high bank 0x2AAA.
  task automatic flash_setup(bit we);
    access(1, 16'h0C00, 8'h01);
    access(1, 16'h1000, {7'd0, we});
    access(1, 16'h2800, 8'h08);
    access(1, 16'h3800, 8'h08);
    access(1, 16'h2000, 8'(2 + 4 * $urandom_range(0, 3)));
    access(1, 16'h3000, 8'(1 + 4 * $urandom_range(0, 31)));
  endtask

  task automatic unlock(logic [7:0] cmd);
    access(1, 16'h5555, KEY_A);
    access(1, 16'h6AAA, KEY_B);
    access(1, 16'h5555, cmd);
  endtask

  task automatic flash_reads(int n);
    repeat (n) access(0, 16'h4000 | 16'($urandom_range(0, 16'h3FFF)), 8'($urandom));
  endtask

  task automatic program_page(bit hidden, logic [6:0] bank);
    logic [15:0] page;
    logic [15:0] last_a;
    if (hidden) begin
      unlock(CMD_EXTENDED);
      access(1, 16'h5555, KEY_A);
      access(1, 16'h6AAA, KEY_B);
      access(1, 16'h5555, CMD_HID_PROG);
    end else unlock(CMD_PROGRAM);
    access(1, 16'h2000, {1'b0, bank});
    page = 16'h4000 | (16'($urandom_range(0, 63)) << 7);
    repeat ($urandom_range(1, 12)) begin
      last_a = page | 16'($urandom_range(0, 127));
      access(1, last_a, 8'($urandom));
    end
    // Repeating the last position commits the page.
    access(1, last_a, 8'($urandom));
    flash_reads(2);
    access(1, 16'h4000, CMD_RESET);
    repeat (3) access(0, page | 16'($urandom_range(0, 127)), 8'h00);
  endtask

  task automatic erase_sector(logic [6:0] bank);
    unlock(CMD_ERASE);
    access(1, 16'h5555, KEY_A);
    access(1, 16'h6AAA, KEY_B);
    access(1, 16'h2000, {1'b0, bank});
    access(1, 16'h4000 | 16'($urandom_range(0, 16'h1FFF)), CMD_SECTOR);
    flash_reads(2);
    access(1, 16'h4000, CMD_RESET);
  endtask

  task automatic second_cmd(logic [7:0] first, logic [7:0] second);
    unlock(first);
    access(1, 16'h5555, KEY_A);
    access(1, 16'h6AAA, KEY_B);
    access(1, 16'h5555, second);
  endtask

  function automatic logic [15:0] noise_address();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h3FFF));
      1, 2: return 16'($urandom_range(16'h4000, 16'h7FFF));
      3: return 16'($urandom_range(16'hA000, 16'hBFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [ROM_SIZE_W-1:0] sizes[$];
    int next_size;
    sizes = '{21'd0, 21'd1, 21'd8191, 21'd8192, 21'd8193, 21'd300000, 21'd1048576};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: address map edges at reset state, then register writes and flash commands.
    foreach (sizes[i]) begin end
    access(0, 16'h0000, 8'h00);
    access(0, 16'h3FFF, 8'h00);
    access(0, 16'h4000, 8'h00);
    access(0, 16'h7FFF, 8'h00);
    access(0, 16'h9FFF, 8'h00);
    access(0, 16'hA000, 8'h00);
    access(0, 16'hFFFF, 8'h00);
    access(1, 16'hC000, 8'hFF);
    access(1, 16'h1001, 8'hFF);
    access(1, 16'h4123, 8'h55);
    access(1, 16'h0000, 8'h0A);
    access(1, 16'h0400, 8'hFF);
    access(1, 16'h0800, 8'h02);
    access(1, 16'hBFFF, 8'h5A);
    access(0, 16'hBFFF, 8'h00);
    access(1, 16'h03FF, 8'h00);
    access(1, 16'h2000, 8'h7F);
    access(0, 16'h5FFF, 8'h00);
    flash_setup(1);
    unlock(CMD_ID);
    access(0, 16'h4000, 8'h00);
    access(0, 16'h4002, 8'h00);
    access(0, 16'h6003, 8'h00);
    access(1, 16'h4000, CMD_RESET);
    program_page(0, 7'd0);
    program_page(1, 7'd0);
    second_cmd(CMD_HIDDEN, CMD_HIDDEN);
    flash_reads(2);
    access(1, 16'h4000, CMD_RESET);
    second_cmd(CMD_EXTENDED, CMD_PROTECT);
    flash_reads(1);
    access(1, 16'h4000, CMD_RESET);
    second_cmd(CMD_ERASE, CMD_CHIP);
    access(1, 16'h4000, CMD_RESET);
    second_cmd(CMD_EXTENDED, CMD_UNPROTECT);
    second_cmd(CMD_EXTENDED, CMD_HID_ERASE);
    access(1, 16'h4000, CMD_RESET);
    erase_sector(7'd127);

    next_size = n_accesses;
    while (n_accesses < 500) begin
      if (n_accesses >= next_size) begin
        if (sizes.size() != 0) set_rom_size(sizes.pop_front());
        else set_rom_size(21'($urandom_range(0, 1048576)));
        next_size = n_accesses + 60;
      end
      if ($urandom_range(0, 9) < 4)
        access($urandom_range(0, 1), noise_address(), 8'($urandom));
      else begin
        flash_setup($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 9))
          0: begin
            unlock(CMD_ID);
            flash_reads(4);
            access(1, 16'h4000, CMD_RESET);
          end
          1, 2: program_page($urandom_range(0, 3) == 0, 7'($urandom));
          3: if ($urandom_range(0, 7) == 0) erase_sector(7'($urandom));
          4: begin
            second_cmd(CMD_HIDDEN, CMD_HIDDEN);
            flash_reads(3);
            access(1, 16'h6000, CMD_RESET);
          end
          5: begin
            second_cmd(CMD_EXTENDED, $urandom_range(0, 1) ? CMD_PROTECT : CMD_UNPROTECT);
            flash_reads(1);
            if ($urandom_range(0, 3) == 0) second_cmd(CMD_EXTENDED, CMD_HID_ERASE);
            access(1, 16'h4000, CMD_RESET);
          end
          6: begin
            // Broken sequence: the first key and second address are sometimes wrong; later data is random.
            access(1, 16'h5555, $urandom_range(0, 1) ? KEY_A : 8'($urandom));
            access(1, $urandom_range(0, 1) ? 16'h6AAA : noise_address(), 8'($urandom));
            access(1, 16'h5555, 8'($urandom));
            flash_reads(1);
          end
          7: begin
            access(1, 16'h0000, $urandom_range(0, 3) ? 8'h0A : 8'($urandom));
            access(1, 16'h0400, 8'($urandom));
            access(1, 16'h0800, 8'($urandom));
            repeat (4) access($urandom_range(0, 1), 16'($urandom_range(16'hA000, 16'hBFFF)),
                              8'($urandom));
          end
          default: begin
            access(1, 16'h2800, 8'($urandom) & 8'hF7);
            access(1, 16'h3800, 8'($urandom) & 8'hF7);
            access(1, 16'h2000, 8'($urandom));
            access(1, 16'h3000, 8'($urandom));
            flash_reads(4);
          end
        endcase
      end
      // Let the queue run dry now and then.
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    $display("Covered %0d accesses over %0d ROM sizes; %0d results compared.",
             n_accesses, n_sizes, checked);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bmf_pkg.sv
rtl/core/bmf_front.sv
rtl/core/bmf_fifo.sv
rtl/core/bmf_back.sv
rtl/core/banked_mapper_with_flash_commands.sv
dv/bmf_checker.sv
dv/tb_banked_mapper_with_flash_commands.sv
